@@ hw/rtl/crc_pkg.sv @@
// Package with types, codes and constants shared by the cooler relay controller.
package crc_pkg;

  // Timing and tolerance constants.
  localparam int unsigned MIN_OFF_MS = 180000;
  localparam int unsigned STABLE_MS  = 660000;
  localparam int unsigned TEMP_TOL   = 10;
  localparam int unsigned HUM_TOL    = 50;
  localparam int unsigned MS_PER_MIN = 60000;

  localparam int unsigned TimerMsW = 27;  // holds 2047 minutes in ms
  localparam int unsigned LeftW    = 22;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RUN_MODE      = 3'd0;
  localparam logic [2:0] CFG_PRIORITY      = 3'd1;
  localparam logic [2:0] CFG_LOWER_TEMP    = 3'd2;
  localparam logic [2:0] CFG_UPPER_TEMP    = 3'd3;
  localparam logic [2:0] CFG_LOWER_HUM     = 3'd4;
  localparam logic [2:0] CFG_UPPER_HUM     = 3'd5;
  localparam logic [2:0] CFG_TIMER_MINUTES = 3'd6;

  // Run modes.
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;
  localparam logic [1:0] MODE_TIMER  = 2'd3;

  // Priority selection.
  localparam logic [1:0] PRIO_TEMP = 2'd0;
  localparam logic [1:0] PRIO_HUM  = 2'd1;
  localparam logic [1:0] PRIO_BOTH = 2'd2;

  // Change sources.
  localparam logic [1:0] SRC_BUTTON  = 2'd0;
  localparam logic [1:0] SRC_AUTO    = 2'd1;
  localparam logic [1:0] SRC_PROTECT = 2'd2;
  localparam logic [1:0] SRC_STABLE  = 2'd3;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [11:0] inside_temp;
    logic [9:0]         inside_hum;
    logic signed [11:0] outside_temp;
    logic [9:0]         outside_hum;
    logic               button_press;
  } crc_in_t;

  typedef struct packed {
    logic             relay_out;
    logic             relay_changed;
    logic [1:0]       change_source;
    logic             timer_event;
    logic             protect_active;
    logic [LeftW-1:0] protect_left_ms;
  } crc_out_t;

  typedef struct packed {
    logic [1:0]          run_mode;
    logic [1:0]          priority_select;
    logic signed [11:0]  off_temp;
    logic signed [11:0]  upper_temp;
    logic [9:0]          off_hum;
    logic [9:0]          upper_hum;
    logic [TimerMsW-1:0] timer_ms;
  } crc_cfg_t;

  typedef struct packed {
    logic        relay;
    logic        protect;
    logic [31:0] off_stamp;
    logic        stable;
    logic [31:0] stable_stamp;
    logic        timer_phase;
    logic [31:0] timer_stamp;
    logic        button_pending;
  } crc_state_t;

endpackage

@@ hw/rtl/crc_core.sv @@
// Next-state and result logic for one control update of the cooler relay.
module crc_core import crc_pkg::*; (
  input  crc_cfg_t   cfg_i,
  input  crc_state_t state_i,
  input  crc_in_t    in_i,
  output crc_state_t state_o,
  output crc_out_t   out_o
);

  localparam logic [31:0]       MinOff   = 32'(MIN_OFF_MS);
  localparam logic [31:0]       StableMs = 32'(STABLE_MS);
  localparam logic signed [12:0] TempTol = 13'(TEMP_TOL);
  localparam logic signed [10:0] HumTol  = 11'(HUM_TOL);

  logic [31:0]        now;
  logic [31:0]        el_off;
  logic [31:0]        el_stable;
  logic [31:0]        el_timer;
  logic [31:0]        el_left;
  logic signed [12:0] temp_diff;
  logic signed [10:0] hum_diff;
  logic               tok;
  logic               hok;
  logic               near_amb;
  logic               btn_on_ok;
  logic               want_keep;
  logic               want_start;
  logic               done;
  logic               want;
  crc_state_t         s;
  logic               chg;
  logic [1:0]         src;
  logic               tev;

  function automatic logic by_prio(logic [1:0] prio, logic t, logic h);
    logic r;
    case (prio)
      PRIO_TEMP: r = t;
      PRIO_HUM:  r = h;
      default:   r = t | h;
    endcase
    return r;
  endfunction

  assign now       = in_i.now_ms;
  assign el_off    = now - state_i.off_stamp;
  assign el_stable = now - state_i.stable_stamp;
  assign el_timer  = now - state_i.timer_stamp;
  assign temp_diff = $signed({in_i.inside_temp[11], in_i.inside_temp})
                   - $signed({in_i.outside_temp[11], in_i.outside_temp});
  assign hum_diff  = $signed({1'b0, in_i.inside_hum}) - $signed({1'b0, in_i.outside_hum});
  assign tok       = temp_diff <= TempTol;
  assign hok       = hum_diff <= HumTol;

  always_comb begin
    case (cfg_i.priority_select)
      PRIO_TEMP: near_amb = tok;
      PRIO_HUM:  near_amb = hok;
      default:   near_amb = tok & hok;
    endcase
  end

  assign btn_on_ok  = by_prio(cfg_i.priority_select,
                              in_i.inside_temp >= cfg_i.off_temp,
                              in_i.inside_hum >= cfg_i.off_hum);
  assign want_keep  = by_prio(cfg_i.priority_select,
                              in_i.inside_temp > cfg_i.off_temp,
                              in_i.inside_hum > cfg_i.off_hum);
  assign want_start = by_prio(cfg_i.priority_select,
                              in_i.inside_temp > cfg_i.upper_temp,
                              in_i.inside_hum > cfg_i.upper_hum);

  always_comb begin
    s                = state_i;
    s.button_pending = state_i.button_pending | in_i.button_press;
    chg              = 1'b0;
    src              = SRC_BUTTON;
    tev              = 1'b0;
    done             = 1'b0;
    want             = 1'b0;

    // Minimum off time: the relay is held off and nothing else happens.
    if (s.protect) begin
      if (el_off >= MinOff) begin
        s.protect = 1'b0;
      end else begin
        if (s.relay) begin
          s.relay     = 1'b0;
          s.off_stamp = now;
          chg         = 1'b1;
          src         = SRC_PROTECT;
        end
        done = 1'b1;
      end
    end

    // Near-ambient watch in auto mode while the relay is on.
    if (!done) begin
      if (s.relay && cfg_i.run_mode == MODE_AUTO && near_amb) begin
        if (!s.stable) begin
          s.stable       = 1'b1;
          s.stable_stamp = now;
        end else if (el_stable >= StableMs) begin
          s.relay        = 1'b0;
          s.off_stamp    = now;
          s.protect      = 1'b1;
          chg            = 1'b1;
          src            = SRC_STABLE;
          s.stable       = 1'b0;
          s.stable_stamp = '0;
          done           = 1'b1;
        end
      end else begin
        s.stable       = 1'b0;
        s.stable_stamp = '0;
      end
    end

    // A pending button request takes precedence over automatic control.
    if (!done && s.button_pending) begin
      s.button_pending = 1'b0;
      done             = 1'b1;
      if (cfg_i.run_mode == MODE_AUTO) begin
        if (!s.relay) begin
          if (btn_on_ok && !s.protect) begin
            s.relay = 1'b1;
            chg     = 1'b1;
            src     = SRC_BUTTON;
          end
        end else begin
          s.relay     = 1'b0;
          s.off_stamp = now;
          s.protect   = 1'b1;
          chg         = 1'b1;
          src         = SRC_BUTTON;
        end
      end else begin
        s.relay = !s.relay;
        if (!s.relay) begin
          s.off_stamp = now;
          s.protect   = 1'b1;
        end
        chg = 1'b1;
        src = SRC_BUTTON;
        if (cfg_i.run_mode == MODE_TIMER) begin
          s.timer_phase = s.relay;
          s.timer_stamp = now;
          tev           = 1'b1;
        end
      end
    end

    if (!done) begin
      want = s.relay;
      if (cfg_i.run_mode == MODE_AUTO) begin
        if (s.relay) begin
          want = want_keep;
        end else if (!s.protect) begin
          want = want_start;
        end
      end else if (cfg_i.run_mode == MODE_TIMER) begin
        // Whole elapsed minutes reach the setting exactly when the elapsed
        // time reaches the setting in milliseconds.
        if (el_timer >= {{(32 - TimerMsW){1'b0}}, cfg_i.timer_ms}
            && (!s.timer_phase || !s.protect)) begin
          s.timer_stamp = now;
          s.timer_phase = !s.timer_phase;
          tev           = 1'b1;
        end
        want = s.timer_phase;
      end
      if (want != s.relay) begin
        s.relay = want;
        if (!want) begin
          s.off_stamp = now;
          s.protect   = 1'b1;
        end
        chg = 1'b1;
        src = SRC_AUTO;
      end
    end
  end

  assign el_left = now - s.off_stamp;

  always_comb begin
    out_o.relay_out       = s.relay;
    out_o.relay_changed   = chg;
    out_o.change_source   = chg ? src : SRC_BUTTON;
    out_o.timer_event     = tev;
    out_o.protect_active  = s.protect;
    out_o.protect_left_ms = '0;
    if (s.protect && el_left < MinOff) begin
      out_o.protect_left_ms = LeftW'(MinOff - el_left);
    end
  end

  assign state_o = s;

endmodule

@@ hw/rtl/cooler_relay_controller_top.sv @@
// Cooler relay controller: request registers, configuration and control state.
// A request is accepted into the input register; its result is loaded into the
// output register when that is empty or being read. Throughput: one request per
// cycle unless out_ready_i stalls; control state updates with the output register.
// Reset: asynchronous, active low; clears control state and loads the
// configuration defaults (auto mode, both priority, 25.0/30.0 C, 50/70 %, 30 min).
module cooler_relay_controller_top import crc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  crc_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output crc_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  crc_cfg_t   cfg_q;
  crc_state_t st_q;
  crc_state_t st_d;
  crc_in_t    in_q;
  logic       in_valid_q;
  crc_out_t   out_q;
  crc_out_t   out_d;
  logic       out_valid_q;
  logic       advance;
  logic       cfg_we;

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Configuration registers; the timer setting is kept in milliseconds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_mode        <= MODE_AUTO;
      cfg_q.priority_select <= PRIO_BOTH;
      cfg_q.off_temp        <= 12'sd250;
      cfg_q.upper_temp      <= 12'sd300;
      cfg_q.off_hum         <= 10'd500;
      cfg_q.upper_hum       <= 10'd700;
      cfg_q.timer_ms        <= TimerMsW'(30 * MS_PER_MIN);
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_RUN_MODE:      cfg_q.run_mode        <= cfg_data_i[1:0];
        CFG_PRIORITY:      cfg_q.priority_select <= cfg_data_i[1:0];
        CFG_LOWER_TEMP:    cfg_q.off_temp        <= $signed(cfg_data_i);
        CFG_UPPER_TEMP:    cfg_q.upper_temp      <= $signed(cfg_data_i);
        CFG_LOWER_HUM:     cfg_q.off_hum         <= cfg_data_i[9:0];
        CFG_UPPER_HUM:     cfg_q.upper_hum       <= cfg_data_i[9:0];
        CFG_TIMER_MINUTES: cfg_q.timer_ms        <=
            TimerMsW'({16'd0, cfg_data_i[10:0]} * 27'(MS_PER_MIN));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  crc_core u_core (
    .cfg_i   (cfg_q),
    .state_i (st_q),
    .in_i    (in_q),
    .state_o (st_d),
    .out_o   (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // The relay can only be on once the minimum off time has run out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.relay |-> !st_q.protect)
    else $error("relay on while off-time protection is set");

  // Remaining time is reported exactly while protection holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.protect_active == (out_q.protect_left_ms != '0)))
    else $error("protection flag and remaining time disagree");

  // An unchanged relay reports no change source.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.relay_changed) |-> (out_q.change_source == SRC_BUTTON))
    else $error("change source set without a relay change");

  // The control state only moves when a request leaves the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && in_valid_q) |=> $stable(st_q))
    else $error("control state changed without a request");
`endif

endmodule
